// ===== hdl/irbp_pkg.sv =====
// irbp_pkg: shared types and constants of the ir burst pattern player
// used by every module of the block; no dependencies

package irbp_pkg;

	// burst table geometry
	localparam int TABLE_DEPTH = 256;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	// section bounds go up to 2*(255+255) before saturation at the depth
	localparam int BOUND_W     = (IDX_W + 1 > 10) ? IDX_W + 1 : 10;
	// total carrier cycles only matter against a 24-bit limit
	localparam int TOT_W       = 25;

	// register reset values
	localparam logic [15:0] CARRIER_TOP_RST = 16'd421;
	localparam logic [23:0] CYCLE_LIMIT_RST = 24'd400000;

	// request kinds carried in tuser
	typedef enum logic [1:0] {
		REQ_LOAD  = 2'd0,
		REQ_START = 2'd1,
		REQ_TICK  = 2'd2
	} req_t;

	// configuration register indexes
	typedef enum logic [1:0] {
		CFG_ONCE_PAIRS   = 2'd0,
		CFG_REPEAT_PAIRS = 2'd1,
		CFG_CARRIER_TOP  = 2'd2,
		CFG_CYCLE_LIMIT  = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic [7:0]  once_pairs;
		logic [7:0]  repeat_pairs;
		logic [15:0] carrier_top;
		logic [23:0] cycle_limit;
	} cfg_t;

	// table write request
	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] addr;
		logic [15:0]      data;
	} tbl_wr_t;

	// one result item
	typedef struct packed {
		logic playing;
		logic envelope_on;
		logic pin_level;
	} res_t;

endpackage

// ===== hdl/irbp_table.sv =====
// irbp_table: burst duration memory, one write and one registered read per cycle
// forwards a write that hits the address read in the same cycle; uses irbp_pkg

module irbp_table (
	input  logic                       clk,
	input  logic                       arst_n,
	input  irbp_pkg::tbl_wr_t          wr,
	input  logic [irbp_pkg::IDX_W-1:0] rd_addr,
	output logic [15:0]                rd_data
);
	import irbp_pkg::*;

	logic [15:0] mem [TABLE_DEPTH];
	logic [15:0] rd_q;
	logic        fwd_s1;
	logic [15:0] fwd_data_s1;

	// storage, read-first
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		rd_q <= mem[rd_addr];
	end

	// same-address write bypass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_s1 <= 1'b0;
		end else begin
			fwd_s1 <= wr.en && (wr.addr == rd_addr);
		end
	end

	always_ff @(posedge clk) begin
		fwd_data_s1 <= wr.data;
	end

	assign rd_data = fwd_s1 ? fwd_data_s1 : rd_q;

endmodule

// ===== hdl/irbp_core.sv =====
// irbp_core: playback state registers and per-transaction update
// reads the current table word from irbp_table; uses irbp_pkg

module irbp_core (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       acc,
	input  logic [1:0]                 req,
	input  logic [7:0]                 word_addr,
	input  logic [15:0]                word_value,
	input  irbp_pkg::cfg_t             cfg,
	input  logic [15:0]                cur_word,
	output irbp_pkg::tbl_wr_t          tbl_wr,
	output logic [irbp_pkg::IDX_W-1:0] rd_addr,
	output irbp_pkg::res_t             res
);
	import irbp_pkg::*;

	logic [15:0]        cc_q, cc_n;
	logic [15:0]        bc_q, bc_n;
	logic [IDX_W-1:0]   idx_q, idx_n;
	logic [TOT_W-1:0]   tot_q, tot_n;
	logic               env_q, env_n;
	logic               run_q, run_n;

	logic [8:0]         pair_sum;
	logic [BOUND_W-1:0] end_raw, sec_end, start_raw, rep_start, idx_inc;
	logic [15:0]        bc_inc;
	logic [TOT_W-1:0]   tot_inc;

	// section bounds, saturated at the table depth
	always_comb begin
		pair_sum  = {1'b0, cfg.once_pairs} + {1'b0, cfg.repeat_pairs};
		end_raw   = BOUND_W'({pair_sum, 1'b0});
		sec_end   = (end_raw > BOUND_W'(TABLE_DEPTH)) ? BOUND_W'(TABLE_DEPTH) : end_raw;
		start_raw = BOUND_W'({cfg.once_pairs, 1'b0});
		rep_start = (start_raw > sec_end) ? sec_end : start_raw;
	end

	// next state for the accepted transaction
	always_comb begin
		cc_n    = cc_q;
		bc_n    = bc_q;
		idx_n   = idx_q;
		tot_n   = tot_q;
		env_n   = env_q;
		run_n   = run_q;
		bc_inc  = bc_q + 16'd1;
		tot_inc = (&tot_q) ? tot_q : tot_q + TOT_W'(1);
		idx_inc = BOUND_W'(idx_q) + BOUND_W'(1);
		tbl_wr.en   = 1'b0;
		tbl_wr.addr = IDX_W'(word_addr % TABLE_DEPTH);
		tbl_wr.data = word_value;
		if (acc) begin
			case (req)
				REQ_LOAD: begin
					tbl_wr.en = 1'b1;
				end
				REQ_START: begin
					cc_n  = '0;
					bc_n  = '0;
					idx_n = '0;
					tot_n = '0;
					run_n = (sec_end != '0);
					env_n = (sec_end != '0);
				end
				REQ_TICK: begin
					if (run_q) begin
						if (cc_q >= cfg.carrier_top) begin
							// one carrier cycle done
							cc_n  = '0;
							tot_n = tot_inc;
							bc_n  = bc_inc;
							if (bc_inc == cur_word) begin
								env_n = !env_q;
								bc_n  = '0;
								idx_n = IDX_W'(idx_inc);
								// wrap into the repeat section
								if (idx_inc >= sec_end) begin
									idx_n = (rep_start == BOUND_W'(TABLE_DEPTH)) ? '0 :
										IDX_W'(rep_start);
									if (rep_start == sec_end ||
											tot_inc > TOT_W'(cfg.cycle_limit)) begin
										run_n = 1'b0;
										env_n = 1'b0;
									end
								end
							end
						end else begin
							cc_n = cc_q + 16'd1;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	// the memory fetches the word for the index of the next cycle
	assign rd_addr = idx_n;

	// result after this transaction
	always_comb begin
		res.pin_level   = env_n && (cc_n > (cfg.carrier_top >> 1));
		res.envelope_on = env_n;
		res.playing     = run_n;
	end

	// playback state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cc_q  <= '0;
			bc_q  <= '0;
			idx_q <= '0;
			tot_q <= '0;
			env_q <= 1'b0;
			run_q <= 1'b0;
		end else begin
			cc_q  <= cc_n;
			bc_q  <= bc_n;
			idx_q <= idx_n;
			tot_q <= tot_n;
			env_q <= env_n;
			run_q <= run_n;
		end
	end

endmodule

// ===== hdl/irbp_out_buf.sv =====
// irbp_out_buf: registered output stage with one skid entry
// keeps the input side ready while one result waits; uses irbp_pkg

module irbp_out_buf (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  irbp_pkg::res_t in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output irbp_pkg::res_t out_data
);
	import irbp_pkg::*;

	logic out_valid_q;
	logic skid_valid_q;
	res_t out_q;
	res_t skid_q;

	assign in_ready  = !skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// output register fed from skid first, then from the input
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || out_ready) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= in_valid;
			end
		end else if (in_valid && in_ready) begin
			skid_valid_q <= 1'b1;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (!out_valid_q || out_ready) begin
			out_q <= skid_valid_q ? skid_q : in_data;
		end else if (in_valid && in_ready) begin
			skid_q <= in_data;
		end
	end

endmodule

// ===== hdl/ir_burst_pattern_player.sv =====
// ir_burst_pattern_player: top level, configuration registers and stream ports
// instantiates irbp_table, irbp_core and irbp_out_buf; uses irbp_pkg

// Plays an infrared mark/space pattern from a 256-word burst table. Every input
// transaction (table load, start, or clock tick) gives exactly one result,
// registered in the output register or the skid entry, so a new transaction
// may follow in every cycle while s_tready is high. The word for the current
// table index is prefetched from the table memory, with bypass of a load to
// that same address, so the burst compare never waits on the memory. The
// output register plus one skid entry keeps s_tready high while one result
// waits on m_tready. Table contents are undefined after reset and are not
// cleared; load every word a pattern uses before starting it.

module ir_burst_pattern_player (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // word_addr[7:0], word_value[23:8]
	input  logic [1:0]  s_tuser,   // req_type[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // pin_level[0], envelope_on[1], playing[2], zero[7:3]
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [23:0] cfg_wdata
);
	import irbp_pkg::*;

	cfg_t             cfg_q;
	logic             acc;
	tbl_wr_t          tbl_wr;
	logic [IDX_W-1:0] rd_addr;
	logic [15:0]      cur_word;
	res_t             res;
	res_t             out_res;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.once_pairs   <= '0;
			cfg_q.repeat_pairs <= '0;
			cfg_q.carrier_top  <= CARRIER_TOP_RST;
			cfg_q.cycle_limit  <= CYCLE_LIMIT_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_ONCE_PAIRS:   cfg_q.once_pairs   <= cfg_wdata[7:0];
				CFG_REPEAT_PAIRS: cfg_q.repeat_pairs <= cfg_wdata[7:0];
				CFG_CARRIER_TOP:  cfg_q.carrier_top  <= cfg_wdata[15:0];
				CFG_CYCLE_LIMIT:  cfg_q.cycle_limit  <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	assign acc = s_tvalid && s_tready;

	irbp_table u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (tbl_wr),
		.rd_addr (rd_addr),
		.rd_data (cur_word)
	);

	irbp_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.acc        (acc),
		.req        (s_tuser),
		.word_addr  (s_tdata[7:0]),
		.word_value (s_tdata[23:8]),
		.cfg        (cfg_q),
		.cur_word   (cur_word),
		.tbl_wr     (tbl_wr),
		.rd_addr    (rd_addr),
		.res        (res)
	);

	irbp_out_buf u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (acc),
		.in_ready  (s_tready),
		.in_data   (res),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (out_res)
	);

	assign m_tdata = {5'b0, out_res.playing, out_res.envelope_on, out_res.pin_level};

	// after every accepted transaction a result is valid on the output in the next cycle
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> m_tvalid)
		else $error("accepted transaction produced no result");

	// input side only stalls after the output was stalled with a result
	a_ready_drop: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(s_tready) |-> $past(m_tvalid && !m_tready))
		else $error("s_tready dropped without output backpressure");

	// pin needs the envelope, the envelope needs playback
	a_result_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (!m_tdata[0] || m_tdata[1]) && (!m_tdata[1] || m_tdata[2]))
		else $error("inconsistent result bits");

endmodule

// ===== sim/tb_top.sv =====
// tb_top: self-checking testbench for the ir burst pattern player
// holds a scoreboard class with its own model of the player; depends on irbp_pkg
`timescale 1ns / 100ps

module tb_top;
	import irbp_pkg::*;

	// request code that the block ignores
	localparam logic [1:0] REQ_NONE = 2'd3;
	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 90;

	// expected results of the player, worked out per accepted transaction
	class irbp_scoreboard;
		bit [15:0]   burst_tbl [TABLE_DEPTH];
		bit [15:0]   carrier_cnt;
		bit [15:0]   burst_cnt;
		int unsigned word_idx;
		bit [31:0]   total_cyc;
		bit          env;
		bit          run;
		bit [7:0]    once_n;
		bit [7:0]    rep_n;
		bit [15:0]   top = CARRIER_TOP_RST;
		bit [23:0]   limit = CYCLE_LIMIT_RST;
		res_t        expected_q [$];
		int          errors;
		int          results;
		int          stops;

		function void set_reg(cfg_idx_t idx, logic [23:0] val);
			case (idx)
				CFG_ONCE_PAIRS:   once_n = val[7:0];
				CFG_REPEAT_PAIRS: rep_n = val[7:0];
				CFG_CARRIER_TOP:  top = val[15:0];
				CFG_CYCLE_LIMIT:  limit = val;
				default: ;
			endcase
		endfunction

		// end of the pattern, saturated at the table depth
		function int unsigned sec_end();
			int unsigned e;
			e = 2 * (once_n + rep_n);
			return (e > TABLE_DEPTH) ? TABLE_DEPTH : e;
		endfunction

		function int unsigned rep_start();
			int unsigned s;
			int unsigned e;
			s = 2 * once_n;
			e = sec_end();
			return (s > e) ? e : s;
		endfunction

		// one full carrier period has passed
		function void carrier_cycle();
			int unsigned stop_at;
			int unsigned wrap_to;
			if (total_cyc != 32'hFFFF_FFFF)
				total_cyc++;
			burst_cnt++;
			if (burst_cnt != burst_tbl[word_idx % TABLE_DEPTH])
				return;
			env = !env;
			burst_cnt = '0;
			word_idx++;
			stop_at = sec_end();
			wrap_to = rep_start();
			if (word_idx >= stop_at) begin
				word_idx = wrap_to;
				// empty repeat section or limit reached ends playback
				if (wrap_to == stop_at || total_cyc > limit) begin
					run = 1'b0;
					env = 1'b0;
					stops++;
				end
			end
		endfunction

		function void note_item(logic [1:0] req, logic [7:0] addr, logic [15:0] val);
			res_t exp;
			bit hi;
			case (req)
				REQ_LOAD: burst_tbl[addr] = val;
				REQ_START: begin
					carrier_cnt = '0;
					burst_cnt = '0;
					word_idx = 0;
					total_cyc = '0;
					run = (sec_end() != 0);
					env = run;
				end
				REQ_TICK: begin
					if (run) begin
						if (carrier_cnt >= top) begin
							carrier_cnt = '0;
							carrier_cycle();
						end else begin
							carrier_cnt++;
						end
					end
				end
				default: ;
			endcase
			hi = carrier_cnt > (top >> 1);
			exp.pin_level = env & hi;
			exp.envelope_on = env;
			exp.playing = run;
			expected_q.push_back(exp);
		endfunction

		function void check_result(logic [7:0] data);
			res_t exp;
			res_t got;
			got = data[2:0];
			if (expected_q.size() == 0) begin
				if (errors < 10)
					$display("result arrived with no transaction outstanding, data %h", data);
				errors++;
				return;
			end
			exp = expected_q.pop_front();
			results++;
			if (got.pin_level !== exp.pin_level || got.envelope_on !== exp.envelope_on ||
					got.playing !== exp.playing || data[7:3] !== 5'd0) begin
				if (errors < 10)
					$display("mismatch at result %0d: exp pin %0b env %0b play %0b,",
						results, exp.pin_level, exp.envelope_on, exp.playing,
						" got pin %0b env %0b play %0b pad %h",
						got.pin_level, got.envelope_on, got.playing, data[7:3]);
				errors++;
			end
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [23:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [23:0] cfg_wdata;

	irbp_scoreboard sb;
	int tx_idle_pct;
	int rx_idle_pct;
	bit rx_hold_req;
	bit loaded [TABLE_DEPTH];
	int n_sent;
	int cycle_count;

	ir_burst_pattern_player dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// run watchdog
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("FAIL ir_burst_pattern_player");
		$finish;
	end

	// result side ready, with random stalls and an occasional long hold-off
	initial begin
		int hold_left;
		hold_left = 0;
		m_tready <= 1'b0;
		forever begin
			@(negedge clk);
			if (rx_hold_req) begin
				hold_left = HOLD_CYCLES;
				rx_hold_req = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
			end
		end
	end

	// check every result transaction
	always @(posedge clk) begin
		if (m_tvalid && m_tready)
			sb.check_result(m_tdata);
	end

	// offer one input transaction and wait for it to be taken
	task automatic send_item(input logic [1:0] req, input logic [7:0] addr,
			input logic [15:0] val);
		@(negedge clk);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= req;
		s_tdata <= {val, addr};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sb.note_item(req, addr, val);
		n_sent++;
		if (req == REQ_LOAD)
			loaded[addr] = 1'b1;
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [23:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		sb.set_reg(idx, val);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// stop offering and let every outstanding result drain
	task automatic wait_idle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic set_pattern(input int unsigned once_cnt, input int unsigned rep_cnt,
			input int unsigned top_val, input int unsigned limit_val);
		wait_idle();
		write_reg(CFG_ONCE_PAIRS, 24'(once_cnt));
		write_reg(CFG_REPEAT_PAIRS, 24'(rep_cnt));
		write_reg(CFG_CARRIER_TOP, 24'(top_val));
		write_reg(CFG_CYCLE_LIMIT, 24'(limit_val));
	endtask

	// one random phase: set up, fill the used table words, start, then mixed traffic
	task automatic run_phase(input int unsigned once_cnt, input int unsigned rep_cnt,
			input int unsigned top_val, input int unsigned limit_val,
			input int tx_pct, input int rx_pct, input int start_pct,
			input int n_rand, input bit hold);
		int unsigned e;
		int r;
		logic [7:0] a;
		logic [15:0] v;
		set_pattern(once_cnt, rep_cnt, top_val, limit_val);
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
		e = 2 * (once_cnt + rep_cnt);
		if (e > TABLE_DEPTH)
			e = TABLE_DEPTH;
		for (int i = 0; i < e; i++) begin
			if (!loaded[i])
				send_item(REQ_LOAD, 8'(i), 16'($urandom_range(1, 2)));
		end
		send_item(REQ_START, 8'($urandom), 16'($urandom));
		if (hold)
			rx_hold_req = 1'b1;
		repeat (n_rand) begin
			r = $urandom_range(0, 99);
			a = 8'($urandom);
			v = 16'($urandom);
			if (r < start_pct) begin
				send_item(REQ_START, a, v);
			end else if (r < start_pct + 2) begin
				send_item(REQ_NONE, a, v);
			end else if (r < start_pct + 10) begin
				// words in use get short durations so playback keeps moving
				if (a < e)
					v = 16'($urandom_range(1, 2));
				send_item(REQ_LOAD, a, v);
			end else begin
				send_item(REQ_TICK, a, v);
			end
		end
	endtask

	// main sequence
	initial begin
		sb = new;
		n_sent = 0;
		rx_hold_req = 1'b0;
		tx_idle_pct = 26;
		rx_idle_pct = 74;
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= REQ_LOAD;
		cfg_we <= 1'b0;
		cfg_index <= CFG_ONCE_PAIRS;
		cfg_wdata <= '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// stopped player: tick, ignored code, start of an empty pattern, edge loads
		send_item(REQ_TICK, 8'h00, 16'h0000);
		send_item(REQ_NONE, 8'hFF, 16'hFFFF);
		send_item(REQ_START, 8'hFF, 16'hFFFF);
		send_item(REQ_LOAD, 8'hFF, 16'hFFFF);
		send_item(REQ_LOAD, 8'h00, 16'h0000);
		send_item(REQ_TICK, 8'hFF, 16'hFFFF);

		// empty repeat section with carrier top zero: stops at the first wrap
		set_pattern(1, 0, 0, 0);
		send_item(REQ_LOAD, 8'h00, 16'd2);
		send_item(REQ_LOAD, 8'h01, 16'd1);
		send_item(REQ_START, 8'h00, 16'h0000);
		repeat (5) send_item(REQ_TICK, 8'h00, 16'h0000);

		// zero duration word, then a restart while playing
		set_pattern(0, 1, 3, 24'hFFFFFF);
		send_item(REQ_LOAD, 8'h00, 16'd1);
		send_item(REQ_LOAD, 8'h01, 16'd0);
		send_item(REQ_START, 8'h00, 16'h0000);
		repeat (8) send_item(REQ_TICK, 8'h00, 16'h0000);
		send_item(REQ_START, 8'h00, 16'h0000);
		repeat (2) send_item(REQ_TICK, 8'h00, 16'h0000);

		// random phases: sender idles less than receiver, then the reverse, then none
		run_phase(2, 3, 2, 40, 26, 74, 2, 200, 1'b0);
		run_phase(100, 100, 0, 300, 26, 74, 0, 360, 1'b0);
		run_phase(0, 2, 1, 24'hFFFFFF, 74, 26, 2, 200, 1'b0);
		run_phase(128, 128, 0, 0, 74, 26, 0, 360, 1'b0);
		run_phase(3, 1, 16'hFFFF, 100, 0, 0, 2, 200, 1'b0);
		run_phase(1, 2, 4, 60, 0, 0, 2, 200, 1'b1);

		wait_idle();
		repeat (10) @(posedge clk);
		$display("sent %0d transactions, checked %0d results, saw %0d playback stops",
			n_sent, sb.results, sb.stops);
		$display("mismatches: %0d", sb.errors);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("PASS ir_burst_pattern_player");
		else
			$display("FAIL ir_burst_pattern_player");
		$finish;
	end

endmodule

// ===== sim.f =====
hdl/irbp_pkg.sv
hdl/irbp_table.sv
hdl/irbp_core.sv
hdl/irbp_out_buf.sv
hdl/ir_burst_pattern_player.sv
sim/tb_top.sv
